// ===== rtl/core/nspt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the nearest snap point table.
// No dependencies; used by nspt_sub and nearest_snap_point_table_core.
package nspt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int TIME_W = 32;  // signed Q16.16
  localparam int DIST_W = 33;  // exact distance between two times
  localparam int ALU_W  = 34;  // signed operand width of the shared subtractor
  localparam int THR_W  = 31;
  localparam int TOL_W  = 16;
  localparam int CFG_W  = 31;  // widest register
  localparam int STS_W  = 3;
  localparam int PCNT_W = 9;

  // Register indexes
  localparam logic REG_SNAP_THRESHOLD  = 1'b0;
  localparam logic REG_MERGE_TOLERANCE = 1'b1;

  // Commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_SNAP   = 2'd2;
  localparam logic [1:0] CMD_GROUP  = 2'd3;

  // Result status
  localparam logic [STS_W-1:0] STS_CLEARED  = 3'd0;
  localparam logic [STS_W-1:0] STS_INSERTED = 3'd1;
  localparam logic [STS_W-1:0] STS_MERGED   = 3'd2;
  localparam logic [STS_W-1:0] STS_FULL     = 3'd3;
  localparam logic [STS_W-1:0] STS_FOUND    = 3'd4;
  localparam logic [STS_W-1:0] STS_NO_SNAP  = 3'd5;

  // Subtractor result
  typedef struct packed {
    logic             neg;
    logic [ALU_W-1:0] diff;
  } sub_res_t;

endpackage

// ===== rtl/core/nspt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nspt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/nspt_sub.sv =====
`timescale 1ns / 1ps
// Shared signed subtractor: every compare and distance of the block goes through it.
// Depends on nspt_pkg.
module nspt_sub (
  input  logic signed [nspt_pkg::ALU_W-1:0] a_i,
  input  logic signed [nspt_pkg::ALU_W-1:0] b_i,
  output nspt_pkg::sub_res_t                res_o
);

  logic signed [nspt_pkg::ALU_W-1:0] diff;

  assign diff       = a_i - b_i;
  assign res_o.diff = diff;
  assign res_o.neg  = diff[nspt_pkg::ALU_W-1];

endmodule

// ===== rtl/core/nearest_snap_point_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the nearest snap point table: sequencer, registers and port logic.
// Depends on nspt_pkg, nspt_ram and nspt_sub.
//
// Usage
//   Input channel (cmd_i, time_value_i, group_last_i): a transfer happens when
//   in_valid_i is high and in_stall_o is low. The block takes one item at a time
//   and raises in_stall_o until that item is finished.
//   Output channel (status_o, snapped_time_o, source_time_o, point_count_o): a
//   transfer happens when out_valid_o is high and out_stall_i is low. A result
//   waits in the output register while the receiver stalls; the sequencer holds
//   a finished result in its emit step until that register is free.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_index_i (0 snap
//   threshold, 1 merge tolerance); the user must write only while no item is
//   in flight; the block itself does not enforce this.
// Operation
//   Commands other than clear run an upper-bound binary search over the sorted
//   table, each step a RAM read, then a compare in the shared subtractor, then
//   fetch both neighbours and run the distance and the tolerance or threshold
//   compares. An insert that is kept then moves the entries above its slot up
//   by one, one entry per cycle on the RAM's single write port, then writes the
//   new point. Group elements that are not last give no result.
// Reset
//   rst_ni clears the table count, group state, registers to their reset
//   values (threshold 1.0, tolerance 0) and the output valid flag. The point
//   store itself is not cleared; only entries below the count are ever read.
module nearest_snap_point_table_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [nspt_pkg::CFG_W-1:0]          cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          cmd_i,
  input  logic signed [nspt_pkg::TIME_W-1:0]  time_value_i,
  input  logic                                group_last_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [nspt_pkg::STS_W-1:0]          status_o,
  output logic signed [nspt_pkg::TIME_W-1:0]  snapped_time_o,
  output logic signed [nspt_pkg::TIME_W-1:0]  source_time_o,
  output logic [nspt_pkg::PCNT_W-1:0]         point_count_o
);

  localparam int IDX_W  = nspt_pkg::IDX_W;
  localparam int CNT_W  = nspt_pkg::CNT_W;
  localparam int TIME_W = nspt_pkg::TIME_W;
  localparam int DIST_W = nspt_pkg::DIST_W;
  localparam int ALU_W  = nspt_pkg::ALU_W;
  localparam int THR_W  = nspt_pkg::THR_W;
  localparam int TOL_W  = nspt_pkg::TOL_W;
  localparam int STS_W  = nspt_pkg::STS_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;   // issue read at mid
  localparam logic [3:0] S_SCMP  = 4'd2;   // compare entry with query
  localparam logic [3:0] S_RDLO  = 4'd3;   // read left neighbour
  localparam logic [3:0] S_RDHI  = 4'd4;   // take left, read right
  localparam logic [3:0] S_CAPHI = 4'd5;   // take right
  localparam logic [3:0] S_DLO   = 4'd6;   // distance to left
  localparam logic [3:0] S_DHI   = 4'd7;   // distance to right
  localparam logic [3:0] S_CMP1  = 4'd8;
  localparam logic [3:0] S_CMP2  = 4'd9;
  localparam logic [3:0] S_CMP3  = 4'd10;  // group best update
  localparam logic [3:0] S_SHIFT = 4'd11;  // open a slot
  localparam logic [3:0] S_PUT   = 4'd12;  // write new point
  localparam logic [3:0] S_EMIT  = 4'd13;

  // ---------------------------------------------------------------- registers
  logic [3:0]              state_q, state_d;
  logic [TIME_W-1:0]       t_q, t_d;
  logic [1:0]              cmd_q, cmd_d;
  logic                    last_q, last_d;
  logic [CNT_W-1:0]        lo_q, lo_d;       // search bound, becomes slot position
  logic [CNT_W-1:0]        hi_q, hi_d;
  logic [IDX_W-1:0]        mid_q, mid_d;
  logic [TIME_W-1:0]       lo_val_q, lo_val_d;
  logic [TIME_W-1:0]       hi_val_q, hi_val_d;
  logic [DIST_W-1:0]       d_lo_q, d_lo_d;
  logic [DIST_W-1:0]       d_hi_q, d_hi_d;
  logic                    flag1_q, flag1_d;
  logic                    found_q, found_d;
  logic [CNT_W-1:0]        rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]        wr_addr_q, wr_addr_d;
  logic                    pend_q, pend_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    grp_has_q, grp_has_d;
  logic [DIST_W-1:0]       grp_delta_q, grp_delta_d;
  logic [TIME_W-1:0]       grp_snap_q, grp_snap_d;
  logic [TIME_W-1:0]       grp_src_q, grp_src_d;
  logic [THR_W-1:0]        thr_q, thr_d;
  logic [TOL_W-1:0]        tol_q, tol_d;
  logic [STS_W-1:0]        res_sts_q, res_sts_d;
  logic [TIME_W-1:0]       res_snap_q, res_snap_d;
  logic [TIME_W-1:0]       res_src_q, res_src_d;
  logic                    out_valid_q, out_valid_d;
  logic [STS_W-1:0]        out_sts_q, out_sts_d;
  logic [TIME_W-1:0]       out_snap_q, out_snap_d;
  logic [TIME_W-1:0]       out_src_q, out_src_d;
  logic [CNT_W-1:0]        out_cnt_q, out_cnt_d;

  // ---------------------------------------------------------------- RAM and subtractor
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [TIME_W-1:0]       ram_wdata, ram_rdata;
  logic signed [ALU_W-1:0] alu_a, alu_b;
  nspt_pkg::sub_res_t      alu;

  nspt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (nspt_pkg::TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  nspt_sub u_sub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  // ---------------------------------------------------------------- helpers
  logic [CNT_W:0]          mid_sum;
  logic                    have_lo, have_hi, pick_lo;
  logic [DIST_W-1:0]       best_d;
  logic [TIME_W-1:0]       best_snap;
  logic                    out_free, upd;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  // slot position is lo_q after the search: left neighbour below it, right at it
  assign have_lo   = (lo_q != '0);
  assign have_hi   = (lo_q != count_q);
  // ties go to the earlier (left) point
  assign pick_lo   = have_lo && (!have_hi || flag1_q);
  assign best_d    = pick_lo ? d_lo_q : d_hi_q;
  assign best_snap = pick_lo ? lo_val_q : hi_val_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  // strictly smaller distance replaces the group best; first element wins ties
  assign upd       = found_q && (!grp_has_q || alu.neg);

  // shared subtractor operands
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      S_SCMP: begin
        alu_a = {{(ALU_W-TIME_W){t_q[TIME_W-1]}}, t_q};
        alu_b = {{(ALU_W-TIME_W){ram_rdata[TIME_W-1]}}, ram_rdata};
      end
      S_DLO: begin
        alu_a = {{(ALU_W-TIME_W){t_q[TIME_W-1]}}, t_q};
        alu_b = {{(ALU_W-TIME_W){lo_val_q[TIME_W-1]}}, lo_val_q};
      end
      S_DHI: begin
        alu_a = {{(ALU_W-TIME_W){hi_val_q[TIME_W-1]}}, hi_val_q};
        alu_b = {{(ALU_W-TIME_W){t_q[TIME_W-1]}}, t_q};
      end
      S_CMP1: begin
        if (cmd_q == nspt_pkg::CMD_INSERT) begin
          alu_a = {{(ALU_W-TOL_W){1'b0}}, tol_q};
          alu_b = {{(ALU_W-DIST_W){1'b0}}, d_lo_q};
        end else begin
          alu_a = {{(ALU_W-DIST_W){1'b0}}, d_hi_q};
          alu_b = {{(ALU_W-DIST_W){1'b0}}, d_lo_q};
        end
      end
      S_CMP2: begin
        if (cmd_q == nspt_pkg::CMD_INSERT) begin
          alu_a = {{(ALU_W-TOL_W){1'b0}}, tol_q};
          alu_b = {{(ALU_W-DIST_W){1'b0}}, d_hi_q};
        end else begin
          alu_a = {{(ALU_W-THR_W){1'b0}}, thr_q};
          alu_b = {{(ALU_W-DIST_W){1'b0}}, best_d};
        end
      end
      S_CMP3: begin
        alu_a = {{(ALU_W-DIST_W){1'b0}}, best_d};
        alu_b = {{(ALU_W-DIST_W){1'b0}}, grp_delta_q};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    cmd_d       = cmd_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    lo_val_d    = lo_val_q;
    hi_val_d    = hi_val_q;
    d_lo_d      = d_lo_q;
    d_hi_d      = d_hi_q;
    flag1_d     = flag1_q;
    found_d     = found_q;
    rd_idx_d    = rd_idx_q;
    wr_addr_d   = wr_addr_q;
    pend_d      = pend_q;
    count_d     = count_q;
    grp_has_d   = grp_has_q;
    grp_delta_d = grp_delta_q;
    grp_snap_d  = grp_snap_q;
    grp_src_d   = grp_src_q;
    thr_d       = thr_q;
    tol_d       = tol_q;
    res_sts_d   = res_sts_q;
    res_snap_d  = res_snap_q;
    res_src_d   = res_src_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_sts_d   = out_sts_q;
    out_snap_d  = out_snap_q;
    out_src_d   = out_src_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        nspt_pkg::REG_SNAP_THRESHOLD:  thr_d = cfg_data_i[THR_W-1:0];
        nspt_pkg::REG_MERGE_TOLERANCE: tol_d = cfg_data_i[TOL_W-1:0];
        default: begin
          thr_d = thr_q;
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d    = time_value_i;
          cmd_d  = cmd_i;
          last_d = group_last_i;
          lo_d   = '0;
          hi_d   = count_q;
          if (cmd_i == nspt_pkg::CMD_CLEAR) begin
            count_d     = '0;
            grp_has_d   = 1'b0;
            grp_delta_d = '0;
            grp_snap_d  = '0;
            grp_src_d   = '0;
            res_sts_d   = nspt_pkg::STS_CLEARED;
            res_snap_d  = '0;
            res_src_d   = '0;
            state_d     = S_EMIT;
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (lo_q == hi_q) begin
          state_d = S_RDLO;
        end else begin
          mid_d     = mid_sum[IDX_W:1];
          ram_re    = 1'b1;
          ram_raddr = mid_sum[IDX_W:1];
          state_d   = S_SCMP;
        end
      end
      S_SCMP: begin
        // entry <= query: slot lies above mid
        if (!alu.neg) begin
          lo_d = CNT_W'(mid_q) + CNT_W'(1);
        end else begin
          hi_d = CNT_W'(mid_q);
        end
        state_d = S_SRCH;
      end
      S_RDLO: begin
        ram_re    = have_lo;
        ram_raddr = IDX_W'(lo_q - CNT_W'(1));
        state_d   = S_RDHI;
      end
      S_RDHI: begin
        if (have_lo) begin
          lo_val_d = ram_rdata;
        end
        ram_re    = have_hi;
        ram_raddr = IDX_W'(lo_q);
        state_d   = S_CAPHI;
      end
      S_CAPHI: begin
        if (have_hi) begin
          hi_val_d = ram_rdata;
        end
        state_d = S_DLO;
      end
      S_DLO: begin
        d_lo_d  = alu.diff[DIST_W-1:0];
        state_d = S_DHI;
      end
      S_DHI: begin
        d_hi_d  = alu.diff[DIST_W-1:0];
        state_d = S_CMP1;
      end
      S_CMP1: begin
        flag1_d = !alu.neg;
        state_d = S_CMP2;
      end
      S_CMP2: begin
        if (cmd_q == nspt_pkg::CMD_INSERT) begin
          res_snap_d = '0;
          res_src_d  = '0;
          if ((have_lo && flag1_q) || (have_hi && !alu.neg)) begin
            res_sts_d = nspt_pkg::STS_MERGED;
            state_d   = S_EMIT;
          end else if (count_q == CNT_W'(nspt_pkg::TABLE_DEPTH)) begin
            res_sts_d = nspt_pkg::STS_FULL;
            state_d   = S_EMIT;
          end else begin
            rd_idx_d = count_q;
            pend_d   = 1'b0;
            state_d  = S_SHIFT;
          end
        end else begin
          found_d = (have_lo || have_hi) && !alu.neg;
          if (cmd_q == nspt_pkg::CMD_SNAP) begin
            if ((have_lo || have_hi) && !alu.neg) begin
              res_sts_d  = nspt_pkg::STS_FOUND;
              res_snap_d = best_snap;
              res_src_d  = t_q;
            end else begin
              res_sts_d  = nspt_pkg::STS_NO_SNAP;
              res_snap_d = '0;
              res_src_d  = '0;
            end
            state_d = S_EMIT;
          end else begin
            state_d = S_CMP3;
          end
        end
      end
      S_CMP3: begin
        if (last_q) begin
          if (grp_has_q || upd) begin
            res_sts_d  = nspt_pkg::STS_FOUND;
            res_snap_d = upd ? best_snap : grp_snap_q;
            res_src_d  = upd ? t_q : grp_src_q;
          end else begin
            res_sts_d  = nspt_pkg::STS_NO_SNAP;
            res_snap_d = '0;
            res_src_d  = '0;
          end
          grp_has_d   = 1'b0;
          grp_delta_d = '0;
          grp_snap_d  = '0;
          grp_src_d   = '0;
          state_d     = S_EMIT;
        end else begin
          if (upd) begin
            grp_has_d   = 1'b1;
            grp_delta_d = best_d;
            grp_snap_d  = best_snap;
            grp_src_d   = t_q;
          end
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        // read entry i while the entry read last cycle, i + 1, lands at i + 2
        ram_we    = pend_q;
        ram_waddr = wr_addr_q + IDX_W'(1);
        ram_wdata = ram_rdata;
        if (rd_idx_q != lo_q) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(rd_idx_q - CNT_W'(1));
          wr_addr_d = IDX_W'(rd_idx_q - CNT_W'(1));
          rd_idx_d  = rd_idx_q - CNT_W'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(lo_q);
        ram_wdata = t_q;
        count_d   = count_q + CNT_W'(1);
        res_sts_d = nspt_pkg::STS_INSERTED;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sts_d   = res_sts_q;
          out_snap_d  = res_snap_q;
          out_src_d   = res_src_q;
          out_cnt_d   = count_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      count_q     <= '0;
      grp_has_q   <= 1'b0;
      grp_delta_q <= '0;
      grp_snap_q  <= '0;
      grp_src_q   <= '0;
      thr_q       <= THR_W'(65536);
      tol_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      count_q     <= count_d;
      grp_has_q   <= grp_has_d;
      grp_delta_q <= grp_delta_d;
      grp_snap_q  <= grp_snap_d;
      grp_src_q   <= grp_src_d;
      thr_q       <= thr_d;
      tol_q       <= tol_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    cmd_q      <= cmd_d;
    last_q     <= last_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    lo_val_q   <= lo_val_d;
    hi_val_q   <= hi_val_d;
    d_lo_q     <= d_lo_d;
    d_hi_q     <= d_hi_d;
    flag1_q    <= flag1_d;
    found_q    <= found_d;
    rd_idx_q   <= rd_idx_d;
    wr_addr_q  <= wr_addr_d;
    res_sts_q  <= res_sts_d;
    res_snap_q <= res_snap_d;
    res_src_q  <= res_src_d;
    out_sts_q  <= out_sts_d;
    out_snap_q <= out_snap_d;
    out_src_q  <= out_src_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_sts_q;
  assign snapped_time_o = out_snap_q;
  assign source_time_o  = out_src_q;
  assign point_count_o  = nspt_pkg::PCNT_W'(out_cnt_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(nspt_pkg::TABLE_DEPTH))
    else $error("point count beyond table depth");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SHIFT || state_q == S_PUT))
    else $error("table written outside insert");

  a_shift_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (count_q < CNT_W'(nspt_pkg::TABLE_DEPTH)))
    else $error("shift with full table");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (lo_q <= hi_q && hi_q <= count_q))
    else $error("search bounds crossed");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("result loaded outside emit step");
`endif

endmodule

// ===== tb/sv/nearest_snap_point_table_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nearest_snap_point_table_core.
// Depends on nspt_pkg and the core RTL; holds its own sorted-table predictor.
module nearest_snap_point_table_core_test;
  import nspt_pkg::*;

  // Cycles allowed after the last result before the block counts as idle.
  // This covers a full search plus a worst-case shift of the whole table.
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_PRINTS    = 60;

  typedef struct {
    logic [1:0]               cmd;
    logic signed [TIME_W-1:0] t;
    logic                     last;
  } table_cmd_t;

  typedef struct {
    logic [STS_W-1:0]         status;
    logic signed [TIME_W-1:0] snapped;
    logic signed [TIME_W-1:0] source;
    logic [PCNT_W-1:0]        count;
  } table_reply_t;

  // DUT connections
  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_index_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               cmd_i        = CMD_CLEAR;
  logic signed [TIME_W-1:0] time_value_i = '0;
  logic                     group_last_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic [STS_W-1:0]         status_o;
  logic signed [TIME_W-1:0] snapped_time_o;
  logic signed [TIME_W-1:0] source_time_o;
  logic [PCNT_W-1:0]        point_count_o;

  nearest_snap_point_table_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .time_value_i  (time_value_i),
    .group_last_i  (group_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .snapped_time_o(snapped_time_o),
    .source_time_o (source_time_o),
    .point_count_o (point_count_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a sorted copy of the table, the group being gathered and
  // the two registers as last written.
  // ---------------------------------------------------------------------------
  logic signed [TIME_W-1:0] sorted_points [TABLE_DEPTH];
  int                       point_total    = 0;
  logic                     grp_found      = 1'b0;
  logic [DIST_W-1:0]        grp_delta      = '0;
  logic signed [TIME_W-1:0] grp_snap       = '0;
  logic signed [TIME_W-1:0] grp_source     = '0;
  logic [THR_W-1:0]         snap_thr       = 31'd65536;
  logic [TOL_W-1:0]         merge_tol      = 16'd0;

  table_cmd_t   cmd_queue[$];      // items waiting for the driver
  table_reply_t table_replies[$];  // predicted results, oldest first

  // Run bookkeeping
  int  err_count   = 0;
  int  items_sent  = 0;
  int  replies_ok  = 0;
  int  cfg_writes  = 0;
  int  status_hits [8];
  bit  quiet       = 1'b0;  // no idling on either side when set

  // Driver state
  bit  in_busy  = 1'b0;  // an item is on the port, not yet transferred
  bit  in_taken = 1'b0;  // set at the edge where that item transferred
  int  in_gap   = 0;
  int  in_calm  = 0;
  int  out_hold = 0;
  int  out_calm = 0;

  // Stimulus generator state
  logic signed [TIME_W-1:0] anchor = '0;
  logic signed [TIME_W-1:0] recent_points[$];

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Exact distance: both times sign-extended, so nothing wraps at the range ends.
  function automatic logic [DIST_W-1:0] time_dist(input logic signed [TIME_W-1:0] a,
                                                  input logic signed [TIME_W-1:0] b);
    logic signed [DIST_W:0] d;
    logic signed [DIST_W:0] m;
    d = {{2{a[TIME_W-1]}}, a} - {{2{b[TIME_W-1]}}, b};
    m = d[DIST_W] ? -d : d;
    return m[DIST_W-1:0];
  endfunction

  // Nearest stored point within the threshold; strict < keeps the earlier point on a tie.
  function automatic bit nearest_point(input logic signed [TIME_W-1:0] t,
                                       output logic signed [TIME_W-1:0] snap,
                                       output logic [DIST_W-1:0] delta);
    bit                found;
    logic [DIST_W-1:0] d;
    found = 1'b0;
    snap  = '0;
    delta = '0;
    for (int i = 0; i < point_total; i++) begin
      d = time_dist(sorted_points[i], t);
      if (d <= snap_thr && (!found || d < delta)) begin
        found = 1'b1;
        delta = d;
        snap  = sorted_points[i];
      end
    end
    return found;
  endfunction

  function automatic void reset_group();
    grp_found  = 1'b0;
    grp_delta  = '0;
    grp_snap   = '0;
    grp_source = '0;
  endfunction

  // Applies one transferred item to the predictor and queues its result, if any.
  function automatic void apply_table_cmd(input logic [1:0] c,
                                          input logic signed [TIME_W-1:0] t,
                                          input logic last);
    table_reply_t             r;
    bit                       merged;
    bit                       hit;
    int                       pos;
    logic signed [TIME_W-1:0] snap;
    logic [DIST_W-1:0]        delta;
    r.snapped = '0;
    r.source  = '0;
    case (c)
      CMD_CLEAR: begin
        point_total = 0;
        reset_group();
        r.status = STS_CLEARED;
      end
      CMD_INSERT: begin
        merged = 1'b0;
        for (int i = 0; i < point_total; i++)
          if (time_dist(sorted_points[i], t) <= merge_tol) merged = 1'b1;
        // a merge is reported even on a full table
        if (merged) begin
          r.status = STS_MERGED;
        end else if (point_total >= TABLE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          pos = 0;
          while (pos < point_total && sorted_points[pos] <= t) pos++;
          for (int j = point_total; j > pos; j--) sorted_points[j] = sorted_points[j-1];
          sorted_points[pos] = t;
          point_total++;
          r.status = STS_INSERTED;
        end
      end
      CMD_SNAP: begin
        // leaves any group being gathered untouched
        if (nearest_point(t, snap, delta)) begin
          r.status  = STS_FOUND;
          r.snapped = snap;
          r.source  = t;
        end else begin
          r.status = STS_NO_SNAP;
        end
      end
      default: begin
        hit = nearest_point(t, snap, delta);
        if (hit && (!grp_found || delta < grp_delta)) begin
          grp_found  = 1'b1;
          grp_delta  = delta;
          grp_snap   = snap;
          grp_source = t;
        end
        if (!last) return;
        if (grp_found) begin
          r.status  = STS_FOUND;
          r.snapped = grp_snap;
          r.source  = grp_source;
        end else begin
          r.status = STS_NO_SNAP;
        end
        reset_group();
      end
    endcase
    r.count = point_total[PCNT_W-1:0];
    table_replies.push_back(r);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t ns] MISMATCH: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. A transfer is taken at the rising edge; the predictor runs on
  // the values seen there. The payload changes only at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      apply_table_cmd(cmd_i, time_value_i, group_last_i);
      items_sent++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    table_cmd_t nxt;
    if (in_taken) begin
      in_taken = 1'b0;
      in_busy  = 1'b0;
    end
    // while busy, valid and payload hold until the transfer
    if (!in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (rst_ni && cmd_queue.size() != 0) begin
        if (!quiet && in_calm == 0 && $urandom_range(0, 11) == 0) begin
          // idle burst, sometimes followed by a calm stretch
          in_gap = $urandom_range(1, 18) - 1;
          if ($urandom_range(0, 3) == 0) in_calm = $urandom_range(20, 200);
          in_valid_i <= 1'b0;
        end else begin
          nxt = cmd_queue.pop_front();
          cmd_i        <= nxt.cmd;
          time_value_i <= nxt.t;
          group_last_i <= nxt.last;
          in_valid_i   <= 1'b1;
          in_busy      = 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (in_calm > 0) in_calm--;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, and the result checker.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall_i <= 1'b1;
    end else if (out_calm == 0 && $urandom_range(0, 9) == 0) begin
      out_hold = $urandom_range(1, 18) - 1;
      if ($urandom_range(0, 3) == 0) out_calm = $urandom_range(20, 200);
      out_stall_i <= 1'b1;
    end else begin
      if (out_calm > 0) out_calm--;
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      status_hits[status_o]++;
      if (table_replies.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d snap %0h src %0h cnt %0d",
                                  status_o, snapped_time_o, source_time_o, point_count_o));
      end else begin
        want = table_replies.pop_front();
        if (status_o !== want.status || snapped_time_o !== want.snapped ||
            source_time_o !== want.source || point_count_o !== want.count)
          report_mismatch($sformatf("got sts %0d snap %h src %h cnt %0d, want sts %0d snap %h src %h cnt %0d",
                                    status_o, snapped_time_o, source_time_o, point_count_o,
                                    want.status, want.snapped, want.source, want.count));
        else
          replies_ok++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(input logic [1:0] c, input logic signed [TIME_W-1:0] t,
                                    input logic last);
    table_cmd_t item;
    item.cmd  = c;
    item.t    = t;
    item.last = last;
    cmd_queue.push_back(item);
    if (c == CMD_INSERT) begin
      recent_points.push_back(t);
      if (recent_points.size() > 64) void'(recent_points.pop_front());
    end
  endfunction

  // base moved by up to +/- span, wrapping at the ends of the range
  function automatic logic signed [TIME_W-1:0] jitter(input logic signed [TIME_W-1:0] base,
                                                      input int span);
    int off;
    off = int'($urandom_range(0, 2 * span)) - span;
    return base + off;
  endfunction

  function automatic logic signed [TIME_W-1:0] edge_time();
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000 + $urandom_range(0, 32'h2_0000);
      default: return 32'sh7FFF_FFFF - $urandom_range(0, 32'h2_0000);
    endcase
  endfunction

  function automatic void pick_anchor();
    case ($urandom_range(0, 3))
      0:       anchor = $urandom();
      1:       anchor = jitter(32'sh0000_0000, 32'h8_0000);
      default: anchor = edge_time();
    endcase
  endfunction

  // Times clustered round an anchor and round earlier points, so that merges,
  // ties and threshold edges come up often; some are fully random.
  function automatic logic signed [TIME_W-1:0] pick_time();
    int unsigned r;
    int          span;
    r    = $urandom_range(0, 99);
    span = 2 * int'(merge_tol) + 3;
    if (r < 35) return jitter(anchor, 32'h4_0000);
    if (r < 55 && recent_points.size() != 0)
      return jitter(recent_points[$urandom_range(0, recent_points.size() - 1)], span);
    if (r < 63 && recent_points.size() != 0)
      return recent_points[$urandom_range(0, recent_points.size() - 1)];
    if (r < 70) return anchor;
    if (r < 82) return edge_time();
    return $urandom();
  endfunction

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_SNAP_THRESHOLD) snap_thr = val[THR_W-1:0];
    else                           merge_tol = val[TOL_W-1:0];
    cfg_writes++;
  endtask

  // Waits until every item has gone in, every result has come out and the
  // block has had time to finish a trailing group element or table shift.
  task automatic drain();
    while (cmd_queue.size() != 0 || in_busy || table_replies.size() != 0 || in_stall_o)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed groups and table updates; a few stray items on top.
  task automatic random_phase(input logic [THR_W-1:0] thr, input logic [TOL_W-1:0] tol,
                              input int n, input int clear_pct, input int insert_pct);
    int          made;
    int unsigned r;
    int          len;
    write_reg(REG_SNAP_THRESHOLD, CFG_W'(thr));
    write_reg(REG_MERGE_TOLERANCE, CFG_W'(tol));
    pick_anchor();
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) pick_anchor();
      if (r < clear_pct) begin
        queue_cmd(CMD_CLEAR, $urandom(), $urandom_range(0, 1));
        made++;
      end else if (r < clear_pct + insert_pct) begin
        queue_cmd(CMD_INSERT, pick_time(), $urandom_range(0, 1));
        made++;
      end else if (r < clear_pct + insert_pct + 15) begin
        queue_cmd(CMD_SNAP, pick_time(), $urandom_range(0, 1));
        made++;
      end else if (r < 97) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          // interleaved items inside a group: the group must survive them,
          // except a clear, which drops it
          if (k != 0 && $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 5))
              0:       queue_cmd(CMD_CLEAR, $urandom(), $urandom_range(0, 1));
              1, 2:    queue_cmd(CMD_INSERT, pick_time(), $urandom_range(0, 1));
              default: queue_cmd(CMD_SNAP, pick_time(), $urandom_range(0, 1));
            endcase
            made++;
          end
          queue_cmd(CMD_GROUP, pick_time(), k == len - 1);
          made++;
        end
      end else begin
        queue_cmd($urandom_range(0, 3), $urandom(), $urandom_range(0, 1));
        made++;
      end
    end
    // close any group a stray element may have opened
    queue_cmd(CMD_GROUP, pick_time(), 1'b1);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [TIME_W-1:0] fill_first;
    logic signed [TIME_W-1:0] v;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_SNAP_THRESHOLD;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings: threshold 1.0, tolerance 0.
    queue_cmd(CMD_CLEAR,  32'sh0000_0000, 1'b0);
    queue_cmd(CMD_SNAP,   32'sh0000_0000, 1'b0);  // empty table
    queue_cmd(CMD_GROUP,  32'sh0000_0005, 1'b1);  // one-element group, empty
    queue_cmd(CMD_INSERT, 32'sh0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 32'sh0000_0000, 1'b0);  // distance 0 merges at tol 0
    queue_cmd(CMD_INSERT, 32'sh0002_0000, 1'b0);
    queue_cmd(CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
    queue_cmd(CMD_INSERT, 32'sh8000_0000, 1'b0);
    queue_cmd(CMD_SNAP,   32'sh0001_0000, 1'b0);  // tie on threshold: earlier wins
    queue_cmd(CMD_SNAP,   32'sh0003_0001, 1'b0);  // just past threshold
    queue_cmd(CMD_SNAP,   32'sh7FFF_0000, 1'b0);  // near the top point
    queue_cmd(CMD_SNAP,   32'sh8001_0000, 1'b0);  // exactly threshold from bottom
    queue_cmd(CMD_SNAP,   32'sh4000_0000, 1'b0);  // far from everything
    queue_cmd(CMD_GROUP,  32'sh0002_8000, 1'b0);
    queue_cmd(CMD_GROUP,  32'sh0001_8000, 1'b0);  // same distance: first element stays
    queue_cmd(CMD_SNAP,   32'sh7FFF_FFFF, 1'b0);  // single query mid-group
    queue_cmd(CMD_GROUP,  32'sh5000_0000, 1'b1);
    queue_cmd(CMD_GROUP,  32'sh0000_0010, 1'b0);
    queue_cmd(CMD_CLEAR,  32'sh7FFF_FFFF, 1'b1);  // drops the open group
    queue_cmd(CMD_INSERT, 32'sh0004_0000, 1'b1);
    queue_cmd(CMD_GROUP,  32'sh0000_0000, 1'b1);
    queue_cmd(CMD_INSERT, 32'shFFFF_FFFF, 1'b1);
    queue_cmd(CMD_SNAP,   32'shFFFF_FFFF, 1'b1);
    queue_cmd(CMD_GROUP,  32'sh7FFF_FFFF, 1'b1);
    drain();

    // Fill the table to its depth with the widest threshold, then try a
    // duplicate (merged although full) and a fresh point (refused).
    write_reg(REG_SNAP_THRESHOLD, CFG_W'(31'h7FFF_FFFF));
    write_reg(REG_MERGE_TOLERANCE, CFG_W'(16'd0));
    queue_cmd(CMD_CLEAR, 32'sh0000_0000, 1'b0);
    fill_first = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      // odd multiplier gives a permutation of the top byte, so every point is
      // distinct and inserts land all over the table
      v = {8'((i * 167) & 8'hFF), 24'($urandom())};
      if (i == 0) fill_first = v;
      queue_cmd(CMD_INSERT, v, $urandom_range(0, 1));
    end
    queue_cmd(CMD_INSERT, fill_first, 1'b0);
    queue_cmd(CMD_INSERT, fill_first ^ 32'sh1, 1'b0);
    queue_cmd(CMD_SNAP, 32'sh8000_0000, 1'b0);
    queue_cmd(CMD_SNAP, 32'sh7FFF_FFFF, 1'b0);
    for (int i = 0; i < 6; i++) queue_cmd(CMD_SNAP, $urandom(), 1'b0);
    queue_cmd(CMD_GROUP, $urandom(), 1'b0);
    queue_cmd(CMD_GROUP, $urandom(), 1'b0);
    queue_cmd(CMD_GROUP, $urandom(), 1'b1);
    drain();

    // Random phases over several register settings, extremes among them.
    random_phase(31'd0,            16'hFFFF,                  250, 3, 35);
    random_phase($urandom(),       $urandom(),                250, 3, 35);
    random_phase(31'h7FFF_FFFF,    16'h0100,                  400, 0, 70);
    random_phase(31'h0004_0000,    16'h1000,                  300, 4, 35);
    random_phase($urandom_range(0, 32'h10_0000), 16'd0,       250, 3, 40);
    quiet = 1'b1;  // last part runs without idling on either side
    random_phase(31'd65536,        16'd1,                     250, 3, 35);

    $display("Summary: %0d items transferred, %0d results matched, %0d register writes",
             items_sent, replies_ok, cfg_writes);
    $display("Results seen: cleared %0d, inserted %0d, merged %0d, full %0d, found %0d, none %0d",
             status_hits[STS_CLEARED], status_hits[STS_INSERTED], status_hits[STS_MERGED],
             status_hits[STS_FULL], status_hits[STS_FOUND], status_hits[STS_NO_SNAP]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Timeout: %0d results still expected", table_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
